### sv/ft3_pkg.sv
// Shared types, constants and a helper function of the FT3 channel extractor.
package ft3_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int CH_CNT_W     = 6;
  localparam int CH_IDX_W     = 5;
  localparam int CODES_W      = 48;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 3;

  localparam logic [1:0] HEADER_BYTES = 2'd2;
  localparam logic [1:0] GAP_BYTES    = 2'd2;
  localparam logic [4:0] GAP_CHAN_A   = 5'd7;
  localparam logic [4:0] GAP_CHAN_B   = 5'd15;

  localparam logic [1:0] CRC_MODE_PERIODIC = 2'd0;
  localparam logic [1:0] CRC_MODE_CHANNEL  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_MODE      = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_CODES_LOW     = 2'd2,
    CFG_CODES_HIGH    = 2'd3
  } ft3_cfg_idx_t;

  typedef struct packed {
    logic [1:0]          crc_mode;
    logic [CH_CNT_W-1:0] channel_count;
    logic [CODES_W-1:0]  codes_low;
    logic [CODES_W-1:0]  codes_high;
  } ft3_cfg_t;

  typedef struct packed {
    logic [CH_IDX_W-1:0] channel_index;
    logic signed [31:0]  channel_value;
    logic                value_valid;
    logic                last_channel;
    logic                frame_truncated;
  } ft3_result_t;

  typedef struct packed {
    logic [1:0]  count;
    ft3_result_t res_a;
    ft3_result_t res_b;
  } ft3_push_t;

  // Applies the length rule to an assembled value; code is length minus one.
  function automatic logic [31:0] finish_value(input logic [2:0] code,
                                               input logic [31:0] acc);
    logic [31:0] v;
    v = acc;
    case (code)
      3'd0:    v = {{24{acc[7]}}, acc[7:0]};
      3'd1:    v = {{16{acc[15]}}, acc[15:0]};
      3'd2:    v = {{8{acc[23]}}, acc[23:0]};
      3'd3:    v = acc;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/ft3_if.sv
// Valid/ready channel interfaces for frame bytes and channel results.
interface ft3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_first, output frame_last,
                  input ready);
  modport sink (input valid, input frame_byte, input frame_first, input frame_last,
                output ready);
endinterface

interface ft3_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         channel_index;
  logic signed [31:0] channel_value;
  logic               value_valid;
  logic               last_channel;
  logic               frame_truncated;

  modport source (output valid, output channel_index, output channel_value,
                  output value_valid, output last_channel, output frame_truncated,
                  input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input value_valid, input last_channel, input frame_truncated,
                output ready);
endinterface

### sv/ft3_parse.sv
// Frame parser: start word, check gaps, channel assembly and truncation detection.
module ft3_parse
  import ft3_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ft3_cfg_t   cfg,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       first,
  input  logic       last,
  output ft3_push_t  push
);

  logic [1:0]          hl_r, hl_nxt, hl;
  logic [CH_CNT_W-1:0] ch_r, ch_nxt, ch;
  logic [3:0]          bic_r, bic_nxt, bic;
  logic [31:0]         acc_r, acc_nxt, acc;
  logic [3:0]          mod_r, mod_nxt, mod16;
  logic [1:0]          gap_r, gap_nxt, gap;

  logic [CH_CNT_W-1:0] nch;
  logic [CODES_W-1:0]  sel_codes;
  logic [5:0]          code_pos;
  logic [2:0]          code;
  logic [3:0]          len;
  logic                done;
  logic                trunc;
  ft3_result_t         done_res, trunc_res;

  assign nch = (cfg.channel_count > CH_CNT_W'(MAX_CHANNELS)) ?
               CH_CNT_W'(MAX_CHANNELS) : cfg.channel_count;

  // A first-byte marker restarts parsing before this byte is looked at.
  assign hl    = first ? HEADER_BYTES : hl_r;
  assign ch    = first ? '0 : ch_r;
  assign bic   = first ? '0 : bic_r;
  assign acc   = first ? '0 : acc_r;
  assign mod16 = first ? '0 : mod_r;
  assign gap   = first ? '0 : gap_r;

  assign sel_codes = ch[4] ? cfg.codes_high : cfg.codes_low;
  assign code_pos  = 6'({2'b00, ch[3:0]} * 6'd3);
  assign code      = sel_codes[code_pos +: 3];
  assign len       = {1'b0, code} + 4'd1;

  always_comb begin
    hl_nxt  = hl;
    ch_nxt  = ch;
    bic_nxt = bic;
    acc_nxt = acc;
    mod_nxt = mod16;
    gap_nxt = gap;
    done    = 1'b0;

    done_res.channel_index   = ch[CH_IDX_W-1:0];
    done_res.channel_value   = finish_value(code, {acc[23:0], data_byte});
    done_res.value_valid     = 1'b1;
    done_res.last_channel    = ((ch + 6'd1) == nch);
    done_res.frame_truncated = 1'b0;

    if (hl != 2'd0) begin
      hl_nxt = hl - 2'd1;
    end else if (gap != 2'd0) begin
      gap_nxt = gap - 2'd1;
    end else if (ch < nch) begin
      acc_nxt = {acc[23:0], data_byte};
      bic_nxt = bic + 4'd1;
      mod_nxt = mod16 + 4'd1;
      if (cfg.crc_mode == CRC_MODE_PERIODIC && mod_nxt == 4'd0) begin
        gap_nxt = GAP_BYTES;
      end
      if (bic_nxt >= len) begin
        done    = 1'b1;
        ch_nxt  = ch + 6'd1;
        bic_nxt = '0;
        acc_nxt = '0;
        if (cfg.crc_mode == CRC_MODE_CHANNEL &&
            (ch[4:0] == GAP_CHAN_A || ch[4:0] == GAP_CHAN_B)) begin
          gap_nxt = GAP_BYTES;
        end
      end
    end

    trunc = last && (ch_nxt < nch);
    trunc_res.channel_index   = ch_nxt[CH_IDX_W-1:0];
    trunc_res.channel_value   = '0;
    trunc_res.value_valid     = 1'b0;
    trunc_res.last_channel    = 1'b0;
    trunc_res.frame_truncated = 1'b1;

    // The end of a frame returns the parser to its restart state.
    if (last) begin
      hl_nxt  = HEADER_BYTES;
      ch_nxt  = '0;
      bic_nxt = '0;
      acc_nxt = '0;
      mod_nxt = '0;
      gap_nxt = '0;
    end

    push.count = {1'b0, done} + {1'b0, trunc};
    push.res_a = done ? done_res : trunc_res;
    push.res_b = trunc_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r  <= HEADER_BYTES;
      ch_r  <= '0;
      bic_r <= '0;
      acc_r <= '0;
      mod_r <= '0;
      gap_r <= '0;
    end else if (step) begin
      hl_r  <= hl_nxt;
      ch_r  <= ch_nxt;
      bic_r <= bic_nxt;
      acc_r <= acc_nxt;
      mod_r <= mod_nxt;
      gap_r <= gap_nxt;
    end
  end

endmodule

### sv/ft3_out_fifo.sv
// Small result queue that takes up to two results per cycle and gives one while out_ready is high.
module ft3_out_fifo
  import ft3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ft3_push_t   push,
  output logic        room2,
  output logic        out_valid,
  input  logic        out_ready,
  output ft3_result_t out_res
);

  ft3_result_t           mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wr_ptr_b;

  assign room2     = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = wr_ptr_r + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_b] <= push.res_b;
    end
  end

endmodule

### sv/ft3_channel_extractor_top.sv
// Top level of the FT3 channel extractor: configuration, input register, parser and result queue.
//
//   Channel  Direction  Handshake        Request carries
//   in_ch    sink       valid/ready      frame_byte, frame_first, frame_last
//   out_ch   source     valid/ready      channel_index, channel_value, value_valid,
//                                        last_channel, frame_truncated
//   cfg_*    sink       write enable     cfg_index, cfg_data (no read-back)
//
// Each accepted byte is held in the input register while the parser works on it; when the
// register is released, its up to two result requests (a completed channel, then a truncation
// flag) are registered into a four-entry result queue, whose head is presented on out_ch.
// A byte is taken every cycle while the queue has room for two more results;
// under output stalls the input register holds and in_ch.ready falls.
// Reset is synchronous and active low; it clears the configuration, parser state and queue.
module ft3_channel_extractor_top
  import ft3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ft3_in_if.sink                in_ch,
  ft3_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ft3_cfg_t    cfg_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic        in_accept;
  logic        advance;
  logic        room2;
  ft3_push_t   push;
  ft3_push_t   push_gated;
  ft3_result_t head;

  // Configuration registers; the user must make writes only while the block is idle; unenforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (ft3_cfg_idx_t'(cfg_index))
        CFG_CRC_MODE:      cfg_r.crc_mode      <= cfg_data[1:0];
        CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[CH_CNT_W-1:0];
        CFG_CODES_LOW:     cfg_r.codes_low     <= cfg_data[CODES_W-1:0];
        CFG_CODES_HIGH:    cfg_r.codes_high    <= cfg_data[CODES_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  // The input register is released into the parser only when the queue can take
  // both results that one byte may cause.
  assign advance      = s1_valid_r && room2;
  assign in_ch.ready  = !s1_valid_r || room2;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_ch.frame_byte;
      s1_first_r <= in_ch.frame_first;
      s1_last_r  <= in_ch.frame_last;
    end
  end

  ft3_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (advance),
    .data_byte (s1_byte_r),
    .first     (s1_first_r),
    .last      (s1_last_r),
    .push      (push)
  );

  // Results are only pushed on a parser step; otherwise the queue sees no request.
  always_comb begin
    push_gated = push;
    if (!advance) begin
      push_gated.count = 2'd0;
    end
  end

  ft3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_gated),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  assign out_ch.channel_index   = head.channel_index;
  assign out_ch.channel_value   = head.channel_value;
  assign out_ch.value_valid     = head.value_valid;
  assign out_ch.last_channel    = head.last_channel;
  assign out_ch.frame_truncated = head.frame_truncated;

endmodule
